>>> rtl/core/sssd_pkg.sv
// Shared types, constants and the character table of the serial scan display driver.
// Used by sssd_engine and seven_segment_serial_scan_driver; depends on nothing.
`default_nettype none

package sssd_pkg;

    // Geometry of the display and of the serial link.
    localparam int NUM_DIGITS_DEF = 8;
    localparam int SLOT_BITS      = 3;
    localparam int SEG_BITS       = 8;
    localparam int DWELL_BITS     = 16;
    localparam int PHASE_BITS     = 17;
    localparam int CLEAR_BITS     = 4;

    // Scan phases inside one slot.
    localparam logic [PHASE_BITS-1:0] SELECT_PHASE = PHASE_BITS'(8);
    localparam logic [PHASE_BITS-1:0] LATCH_PHASE  = PHASE_BITS'(16);

    // Clear sequence steps.
    localparam logic [CLEAR_BITS-1:0] CLEAR_IDLE  = CLEAR_BITS'(0);
    localparam logic [CLEAR_BITS-1:0] CLEAR_FIRST = CLEAR_BITS'(1);
    localparam logic [CLEAR_BITS-1:0] CLEAR_LATCH = CLEAR_BITS'(2);
    localparam logic [CLEAR_BITS-1:0] CLEAR_LAST  = CLEAR_BITS'(11);

    // Character mapping.
    localparam logic [7:0] FIRST_CODE = 8'd48;
    localparam int         CODE_COUNT = 18;
    localparam logic [SEG_BITS-1:0] BLANK_SEG  = 8'hFF;
    localparam logic [SEG_BITS-1:0] SELECT_TOP = 8'h80;

    // Active-low segment patterns: 0-9, A-F, dash, dot.
    localparam logic [SEG_BITS-1:0] SEG_TABLE [CODE_COUNT] = '{
        8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01,
        8'h09, 8'h11, 8'hC1, 8'h63, 8'h85, 8'h61, 8'h71, 8'hFD, 8'hFE
    };

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    // Pin state produced for one word.
    typedef struct packed {
        logic data;
        logic shift;
        logic latch;
    } t_pins;

    // Maps a character byte to its segment byte; unknown codes give a blank digit.
    function automatic logic [SEG_BITS-1:0] char_to_seg(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - FIRST_CODE;
        if (code >= FIRST_CODE && offs < 8'(CODE_COUNT)) begin
            return SEG_TABLE[offs[4:0]];
        end
        return BLANK_SEG;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sssd_engine.sv
// Scan and clear sequencer of the serial scan display driver: holds the digit store
// and the sequence state, and produces one pin state per stepped word. Uses sssd_pkg.
`default_nettype none

module sssd_engine #(
    parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_step,
    input  wire  [1:0]                          i_kind,
    input  wire  [sssd_pkg::SLOT_BITS-1:0]      i_slot,
    input  wire  [7:0]                          i_char_code,
    input  wire  [sssd_pkg::DWELL_BITS-1:0]     i_dwell_ticks,
    output sssd_pkg::t_pins                     o_pins
);

    localparam int SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DIGITS - 1);

    // Digit store and sequence state.
    logic [sssd_pkg::SEG_BITS-1:0]   r_seg [NUM_DIGITS];
    logic                            r_scanning,  n_scanning;
    logic [sssd_pkg::PHASE_BITS-1:0] r_phase,     n_phase;
    logic [SLOT_W-1:0]               r_cur_slot,  n_cur_slot;
    logic [sssd_pkg::CLEAR_BITS-1:0] r_clear,     n_clear;
    logic                            r_level;

    sssd_pkg::t_kind                 kind;
    logic [sssd_pkg::SEG_BITS-1:0]   cur_seg;
    logic [sssd_pkg::SEG_BITS-1:0]   cur_sel;
    logic [sssd_pkg::PHASE_BITS-1:0] dwell_end;
    logic                            load_ok;

    assign kind      = sssd_pkg::t_kind'(i_kind);
    assign cur_seg   = r_seg[r_cur_slot];
    assign cur_sel   = sssd_pkg::SELECT_TOP >> r_cur_slot;
    assign dwell_end = sssd_pkg::LATCH_PHASE + sssd_pkg::PHASE_BITS'(i_dwell_ticks);
    assign load_ok   = ({1'b0, i_slot} < 4'(NUM_DIGITS));

    // Pin state and next sequence state for the word being stepped.
    always_comb begin
        o_pins       = '{data: r_level, shift: 1'b0, latch: 1'b0};
        n_scanning   = r_scanning;
        n_phase      = r_phase;
        n_cur_slot   = r_cur_slot;
        n_clear      = r_clear;
        case (kind)
            sssd_pkg::KIND_LOAD: begin
            end
            sssd_pkg::KIND_START: begin
                n_scanning = 1'b1;
                n_phase    = '0;
                n_cur_slot = '0;
                n_clear    = sssd_pkg::CLEAR_IDLE;
            end
            sssd_pkg::KIND_STOP: begin
                n_scanning = 1'b0;
                n_phase    = '0;
                n_cur_slot = '0;
                n_clear    = sssd_pkg::CLEAR_FIRST;
            end
            default: begin
                if (r_clear != sssd_pkg::CLEAR_IDLE) begin
                    // Clear sequence: shift at the held level, latch, eight zeros, latch.
                    if (r_clear == sssd_pkg::CLEAR_FIRST) begin
                        o_pins.shift = 1'b1;
                    end else if (r_clear == sssd_pkg::CLEAR_LATCH) begin
                        o_pins.latch = 1'b1;
                    end else if (r_clear >= sssd_pkg::CLEAR_LAST) begin
                        o_pins.latch = 1'b1;
                        o_pins.data  = 1'b0;
                    end else begin
                        o_pins.shift = 1'b1;
                        o_pins.data  = 1'b0;
                    end
                    n_clear = (r_clear >= sssd_pkg::CLEAR_LAST) ? sssd_pkg::CLEAR_IDLE
                                                                : r_clear + 1'b1;
                end else if (r_scanning) begin
                    // Segment byte, then select byte, both LSB first, then latch and dwell.
                    if (r_phase < sssd_pkg::SELECT_PHASE) begin
                        o_pins.data  = cur_seg[r_phase[2:0]];
                        o_pins.shift = 1'b1;
                    end else if (r_phase < sssd_pkg::LATCH_PHASE) begin
                        o_pins.data  = cur_sel[r_phase[2:0]];
                        o_pins.shift = 1'b1;
                    end else if (r_phase == sssd_pkg::LATCH_PHASE) begin
                        o_pins.latch = 1'b1;
                    end
                    if (r_phase >= dwell_end) begin
                        n_phase    = '0;
                        n_cur_slot = (r_cur_slot == LAST_SLOT) ? '0 : r_cur_slot + 1'b1;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
        endcase
    end

    // Sequence state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_phase    <= '0;
            r_cur_slot <= '0;
            r_clear    <= sssd_pkg::CLEAR_IDLE;
            r_level    <= 1'b0;
        end else if (i_step) begin
            r_scanning <= n_scanning;
            r_phase    <= n_phase;
            r_cur_slot <= n_cur_slot;
            r_clear    <= n_clear;
            r_level    <= o_pins.data;
        end
    end

    // Digit store; every digit starts blank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_seg[i] <= sssd_pkg::BLANK_SEG;
            end
        end else if (i_step && kind == sssd_pkg::KIND_LOAD && load_ok) begin
            r_seg[i_slot[SLOT_W-1:0]] <= sssd_pkg::char_to_seg(i_char_code);
        end
    end

    // A scan and a clear never run together.
    a_scan_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_scanning && r_clear != sssd_pkg::CLEAR_IDLE))
        else $error("scan and clear active together");

    // The clear step never runs past its last step.
    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clear <= sssd_pkg::CLEAR_LAST)
        else $error("clear step out of range");

    // A stop word arms the first clear step.
    a_stop_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && kind == sssd_pkg::KIND_STOP) |=> r_clear == sssd_pkg::CLEAR_FIRST)
        else $error("stop did not arm the clear sequence");

    // A nonzero phase only exists while scanning.
    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != '0) |-> r_scanning)
        else $error("scan phase moved while stopped");

    // Shift and latch never pulse on the same tick.
    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_pins.shift && o_pins.latch))
        else $error("shift and latch pulsed together");

endmodule

`default_nettype wire

>>> rtl/core/seven_segment_serial_scan_driver.sv
// A word is taken into the input register, processed by sssd_engine, and its result is
// taken into the result register, which drives the output channel.
// Throughput: one word per cycle while the output is not stalled; the input register and the
// output register each take a new word whenever the register behind them frees up.
// Reset (synchronous, active low) blanks all digits, stops scanning, drops any clear and
// sets the dwell register to 0. Top level; uses sssd_pkg and sssd_engine.
`default_nettype none

module seven_segment_serial_scan_driver #(
    parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration write
    input  wire                                 i_cfg_we,
    input  wire  [sssd_pkg::DWELL_BITS-1:0]     i_cfg_wdata,
    // Input channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [1:0]                          i_kind,
    input  wire  [sssd_pkg::SLOT_BITS-1:0]      i_slot,
    input  wire  [7:0]                          i_char_code,
    // Output channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_data_pin,
    output logic                                o_shift_pulse,
    output logic                                o_latch_pulse
);

    logic [sssd_pkg::DWELL_BITS-1:0] r_dwell;

    logic                            r_in_valid;
    logic [1:0]                      r_kind;
    logic [sssd_pkg::SLOT_BITS-1:0]  r_slot;
    logic [7:0]                      r_char_code;

    logic                            r_out_valid;
    sssd_pkg::t_pins                 r_pins;

    logic                            out_free;
    logic                            in_free;
    logic                            step;
    sssd_pkg::t_pins                 pins;

    // Handshake: each stage takes a word when the stage behind it frees up.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign in_free    = !r_in_valid || out_free;
    assign o_in_stall = !in_free;

    // Dwell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell <= '0;
        end else if (i_cfg_we) begin
            r_dwell <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_kind      <= i_kind;
            r_slot      <= i_slot;
            r_char_code <= i_char_code;
        end
    end

    sssd_engine #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_kind       (r_kind),
        .i_slot       (r_slot),
        .i_char_code  (r_char_code),
        .i_dwell_ticks(r_dwell),
        .o_pins       (pins)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_pins <= pins;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_pin    = r_pins.data;
    assign o_shift_pulse = r_pins.shift;
    assign o_latch_pulse = r_pins.latch;

endmodule

`default_nettype wire
